// File: rtl/core/fpc_pkg.sv
// shared constants and types of the filtered pi controller
package fpc_pkg;

    localparam int DATA_W      = 48;
    localparam int DT_W        = 47;
    localparam int MUL_W       = 49;
    localparam int SUM_W       = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int FRAC_BITS_DEF   = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INT_GAIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDUP     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UPPER      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWER      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FILT_NORM  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FILT_COEF2 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_FILT_COEF1 = 3'd7;

    // register reset values
    localparam logic signed [DATA_W-1:0] RST_PROP_GAIN  = 48'sd4294967296;
    localparam logic signed [DATA_W-1:0] RST_INT_GAIN   = 48'sd0;
    localparam logic [DT_W-1:0]          RST_WINDUP     = 47'd4294967296000;
    localparam logic signed [DATA_W-1:0] RST_UPPER      = 48'sd4294967296000;
    localparam logic signed [DATA_W-1:0] RST_LOWER      = -48'sd4294967296000;
    localparam logic signed [DATA_W-1:0] RST_FILT_NORM  = 48'sd1258047461;
    localparam logic signed [DATA_W-1:0] RST_FILT_COEF2 = 48'sd2516850835;
    localparam logic signed [DATA_W-1:0] RST_FILT_COEF1 = 48'sd0;

    // request to the shared multiplier
    typedef struct packed {
        logic start;
        logic wide;   // saturate to 49 bits instead of 48
    } mul_req_t;

endpackage

// File: rtl/core/fpc_mul.sv
// shared fixed point multiplier, 24x24 partial products, floor shift and saturate
module fpc_mul #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fpc_pkg::mul_req_t                     req,
    input  logic signed [fpc_pkg::DATA_W-1:0]     a,
    input  logic signed [fpc_pkg::DATA_W-1:0]     b,
    output logic                                  done,
    output logic signed [fpc_pkg::MUL_W-1:0]      result
);
    import fpc_pkg::*;

    localparam int HALF_W = DATA_W / 2;
    localparam int PROD_W = 2 * DATA_W;
    localparam logic signed [PROD_W-1:0] HI48 = (96'sd1 <<< 47) - 96'sd1;
    localparam logic signed [PROD_W-1:0] HI49 = (96'sd1 <<< 48) - 96'sd1;

    logic signed [DATA_W-1:0] a_reg, b_reg;
    logic [DATA_W-1:0]        ma_reg, mb_reg;
    logic                     neg_reg, wide_reg, busy_reg, done_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [2:0]               step_reg;
    logic signed [MUL_W-1:0]  result_reg;

    logic [HALF_W-1:0]        x, y;
    logic [DATA_W-1:0]        pp;
    logic [PROD_W-1:0]        pp_shift;
    logic signed [PROD_W-1:0] shifted, hi, lo;

    always_comb
    begin
        x = ma_reg[HALF_W-1:0];
        y = mb_reg[HALF_W-1:0];
        pp_shift = '0;
        case (step_reg)
            3'd1:
            begin
                x = ma_reg[HALF_W-1:0];
                y = mb_reg[HALF_W-1:0];
            end
            3'd2:
            begin
                x = ma_reg[DATA_W-1:HALF_W];
                y = mb_reg[HALF_W-1:0];
            end
            3'd3:
            begin
                x = ma_reg[HALF_W-1:0];
                y = mb_reg[DATA_W-1:HALF_W];
            end
            3'd4:
            begin
                x = ma_reg[DATA_W-1:HALF_W];
                y = mb_reg[DATA_W-1:HALF_W];
            end
            default:
            begin
                x = ma_reg[HALF_W-1:0];
                y = mb_reg[HALF_W-1:0];
            end
        endcase
        pp = x * y;
        case (step_reg)
            3'd2, 3'd3: pp_shift = {{DATA_W{1'b0}}, pp} << HALF_W;
            3'd4:       pp_shift = {{DATA_W{1'b0}}, pp} << DATA_W;
            default:    pp_shift = {{DATA_W{1'b0}}, pp};
        endcase
        shifted = $signed(acc_reg) >>> FRAC_BITS;
        hi = wide_reg ? HI49 : HI48;
        lo = -hi - 96'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            wide_reg <= req.wide;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                3'd0:
                begin
                    ma_reg  <= a_reg[DATA_W-1] ? DATA_W'(-a_reg) : DATA_W'(a_reg);
                    mb_reg  <= b_reg[DATA_W-1] ? DATA_W'(-b_reg) : DATA_W'(b_reg);
                    neg_reg <= a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                    acc_reg <= '0;
                end
                3'd1, 3'd2, 3'd3, 3'd4: acc_reg <= acc_reg + pp_shift;
                3'd5: if (neg_reg) acc_reg <= -acc_reg;
                3'd6:
                begin
                    if (shifted > hi)
                        result_reg <= hi[MUL_W-1:0];
                    else if (shifted < lo)
                        result_reg <= lo[MUL_W-1:0];
                    else
                        result_reg <= shifted[MUL_W-1:0];
                end
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/fpc_div.sv
// restoring divider for the running mean, one quotient bit a cycle
module fpc_div #(
    parameter int COUNT_WIDTH = fpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [fpc_pkg::SUM_W-1:0]    num,
    input  logic [COUNT_WIDTH-1:0]              den,
    output logic                                done,
    output logic signed [fpc_pkg::DATA_W-1:0]   result
);
    import fpc_pkg::*;

    localparam logic [SUM_W-1:0] MAG_MAX = 64'h0000_7FFF_FFFF_FFFF;

    logic [SUM_W-1:0]        q_reg;
    logic [COUNT_WIDTH:0]    rem_reg;
    logic [COUNT_WIDTH-1:0]  den_reg;
    logic                    neg_reg, busy_reg, done_reg;
    logic [6:0]              cnt_reg;
    logic signed [DATA_W-1:0] result_reg;

    logic [COUNT_WIDTH:0]    trial;
    logic                    fits;

    assign trial = {rem_reg[COUNT_WIDTH-1:0], q_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(SUM_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[SUM_W-1] ? -num : num;
            neg_reg <= num[SUM_W-1];
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 7'(SUM_W))
            begin
                rem_reg <= fits ? trial - {1'b0, den_reg} : trial;
                q_reg   <= {q_reg[SUM_W-2:0], fits};
            end
            else
            begin
                // sign and saturate to 48 bits
                if (!neg_reg && q_reg > MAG_MAX)
                    result_reg <= MAG_MAX[DATA_W-1:0];
                else if (neg_reg && q_reg > MAG_MAX + 64'd1)
                    result_reg <= -MAG_MAX[DATA_W-1:0] - 48'd1;
                else if (neg_reg)
                    result_reg <= -q_reg[DATA_W-1:0];
                else
                    result_reg <= q_reg[DATA_W-1:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/filtered_pi_controller.sv
// filtered pi controller top level: sequencer, state and configuration
// a skipped item leaves the sequencer idle; a step runs six multiplier passes, one after another
// an enabled step then launches the mean divider, waits for it and loads the output register
// throughput: ready only while idle: one beat a cycle when skipped; a disabled or enabled step
// must finish before the next beat, and an enabled step also waits while a result stalls the output
// reset (async, active low) clears history, integral, effort, mean and loads register defaults
module filtered_pi_controller #(
    parameter int FRAC_BITS   = fpc_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = fpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [95:0]                       s_axis_tdata,  // plant_sample, delta_time, pad
    input  logic                              s_axis_tuser,  // enable
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [191:0]                      m_axis_tdata,  // control effort, new_setpoint,
                                                             // proportional_term, integral_term
    input  logic                              cfg_we,
    input  logic [fpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fpc_pkg::DATA_W-1:0]        cfg_data
);
    import fpc_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INT  = 4'd1;  // integral increment
    localparam logic [3:0] S_F2   = 4'd2;  // coef_two product
    localparam logic [3:0] S_F1   = 4'd3;  // coef_one product
    localparam logic [3:0] S_FN   = 4'd4;  // normalizer product
    localparam logic [3:0] S_P    = 4'd5;  // proportional product
    localparam logic [3:0] S_I    = 4'd6;  // integral product, effort update
    localparam logic [3:0] S_DGO  = 4'd7;  // launch mean divide
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic signed [51:0] SAT_HI = (52'sd1 <<< 47) - 52'sd1;
    localparam logic signed [51:0] SAT_LO = -(52'sd1 <<< 47);

    // configuration
    logic signed [DATA_W-1:0] kp_reg, ki_reg, upper_reg, lower_reg;
    logic signed [DATA_W-1:0] norm_reg, coef2_reg, coef1_reg;
    logic [DT_W-1:0]          windup_reg;

    // controller state
    logic [3:0]               state_reg;
    logic                     armed_reg, en_reg;
    logic signed [DATA_W-1:0] e0_reg, e1_reg, e2_reg;
    logic signed [DATA_W-1:0] f0_reg, f1_reg;
    logic signed [DATA_W-1:0] integral_reg, effort_reg, setpoint_reg;
    logic signed [DATA_W-1:0] prop_reg, integ_reg, sample_reg;
    logic signed [51:0]       tsum_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;

    // output register
    logic                     out_valid_reg;
    logic [191:0]             out_data_reg;

    // shared units
    mul_req_t                 mul_req;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic                     mul_done;
    logic signed [MUL_W-1:0]  mul_res;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_res;

    // input fields
    logic signed [DATA_W-1:0] in_sample;
    logic [DT_W-1:0]          in_dt;
    logic                     accept;

    // datapath
    logic signed [DATA_W:0]   err_wide;
    logic signed [DATA_W-1:0] err_new;
    logic signed [49:0]       int_acc, int_w, eff_acc;
    logic signed [DATA_W-1:0] int_clamped, eff_clamped;
    logic signed [51:0]       fsum;
    logic signed [DATA_W-1:0] fsum_sat;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_new;
    logic                     out_load;

    assign in_sample = $signed(s_axis_tdata[DATA_W-1:0]);
    assign in_dt     = s_axis_tdata[DATA_W+DT_W-1:DATA_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        // setpoint minus sample, saturated
        err_wide = {setpoint_reg[DATA_W-1], setpoint_reg} - {in_sample[DATA_W-1], in_sample};
        if (err_wide[DATA_W] != err_wide[DATA_W-1])
            err_new = err_wide[DATA_W] ? SAT_LO[DATA_W-1:0] : SAT_HI[DATA_W-1:0];
        else
            err_new = err_wide[DATA_W-1:0];

        // integral clamp to +-windup
        int_w   = {3'b000, windup_reg};
        int_acc = 50'(integral_reg) + 50'(mul_res);
        if (int_acc > int_w)
            int_clamped = int_w[DATA_W-1:0];
        else if (int_acc < -int_w)
            int_clamped = DATA_W'(-int_w);
        else
            int_clamped = int_acc[DATA_W-1:0];

        // filter bracket, saturated
        fsum = tsum_reg - 52'($signed(mul_res[DATA_W-1:0]));
        if (fsum > SAT_HI)
            fsum_sat = SAT_HI[DATA_W-1:0];
        else if (fsum < SAT_LO)
            fsum_sat = SAT_LO[DATA_W-1:0];
        else
            fsum_sat = fsum[DATA_W-1:0];

        // effort, upper limit tested first
        eff_acc = 50'(effort_reg) + 50'(prop_reg) + 50'($signed(mul_res[DATA_W-1:0]));
        if (eff_acc > 50'(upper_reg))
            eff_clamped = upper_reg;
        else if (eff_acc < 50'(lower_reg))
            eff_clamped = lower_reg;
        else
            eff_clamped = eff_acc[DATA_W-1:0];

        // running sum, saturating
        sum_wide = {sum_reg[SUM_W-1], sum_reg} + 65'(sample_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_new = sum_wide[SUM_W-1:0];

        // multiplier requests
        mul_req.start = 1'b0;
        mul_req.wide  = 1'b0;
        mul_a = err_new;
        mul_b = {1'b0, in_dt};
        case (state_reg)
            S_IDLE:
            begin
                mul_req.start = accept && armed_reg && (in_dt != '0);
                mul_req.wide  = 1'b1;
            end
            S_INT:
            begin
                mul_req.start = mul_done;
                mul_a = coef2_reg;
                mul_b = f1_reg;
            end
            S_F2:
            begin
                mul_req.start = mul_done;
                mul_a = coef1_reg;
                mul_b = f1_reg;
            end
            S_F1:
            begin
                mul_req.start = mul_done;
                mul_a = norm_reg;
                mul_b = fsum_sat;
            end
            S_FN:
            begin
                mul_req.start = mul_done;
                mul_a = kp_reg;
                mul_b = mul_res[DATA_W-1:0];
            end
            S_P:
            begin
                mul_req.start = mul_done;
                mul_a = ki_reg;
                mul_b = integral_reg;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    fpc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    fpc_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_DGO),
        .num    (sum_reg),
        .den    (count_reg),
        .done   (div_done),
        .result (div_res)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= RST_PROP_GAIN;
            ki_reg     <= RST_INT_GAIN;
            windup_reg <= RST_WINDUP;
            upper_reg  <= RST_UPPER;
            lower_reg  <= RST_LOWER;
            norm_reg   <= RST_FILT_NORM;
            coef2_reg  <= RST_FILT_COEF2;
            coef1_reg  <= RST_FILT_COEF1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PROP_GAIN:  kp_reg     <= cfg_data;
                REG_INT_GAIN:   ki_reg     <= cfg_data;
                REG_WINDUP:     windup_reg <= cfg_data[DT_W-1:0];
                REG_UPPER:      upper_reg  <= cfg_data;
                REG_LOWER:      lower_reg  <= cfg_data;
                REG_FILT_NORM:  norm_reg   <= cfg_data;
                REG_FILT_COEF2: coef2_reg  <= cfg_data;
                REG_FILT_COEF1: coef1_reg  <= cfg_data;
                default:        kp_reg     <= kp_reg;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= 1'b0;
            en_reg        <= 1'b0;
            e0_reg        <= '0;
            e1_reg        <= '0;
            e2_reg        <= '0;
            f0_reg        <= '0;
            f1_reg        <= '0;
            integral_reg  <= '0;
            effort_reg    <= '0;
            setpoint_reg  <= '0;
            tsum_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        e2_reg <= e1_reg;
                        e1_reg <= e0_reg;
                        e0_reg <= err_new;
                        en_reg <= s_axis_tuser;
                        armed_reg <= 1'b1;
                        if (armed_reg && in_dt != '0)
                            state_reg <= S_INT;
                    end
                end
                S_INT:
                begin
                    if (mul_done)
                    begin
                        integral_reg <= int_clamped;
                        f1_reg <= f0_reg;
                        tsum_reg <= 52'(e2_reg) + (52'(e1_reg) <<< 1) + 52'(e0_reg);
                        state_reg <= S_F2;
                    end
                end
                S_F2:
                begin
                    if (mul_done)
                    begin
                        tsum_reg  <= fsum;
                        state_reg <= S_F1;
                    end
                end
                S_F1:
                begin
                    if (mul_done)
                        state_reg <= S_FN;
                end
                S_FN:
                begin
                    if (mul_done)
                    begin
                        f0_reg    <= mul_res[DATA_W-1:0];
                        state_reg <= S_P;
                    end
                end
                S_P:
                begin
                    if (mul_done)
                        state_reg <= S_I;
                end
                S_I:
                begin
                    if (mul_done)
                    begin
                        effort_reg <= eff_clamped;
                        if (en_reg)
                        begin
                            sum_reg <= sum_new;
                            if (count_reg != {COUNT_WIDTH{1'b1}})
                                count_reg <= count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                            state_reg <= S_DGO;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_DGO:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        setpoint_reg <= div_res;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= in_sample;
        if (state_reg == S_P && mul_done)
            prop_reg <= mul_res[DATA_W-1:0];
        if (state_reg == S_I && mul_done)
            integ_reg <= mul_res[DATA_W-1:0];
        if (out_load)
            out_data_reg <= {integ_reg, prop_reg, setpoint_reg, effort_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // multiplier only reports while a step is running
    a_mul_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg != S_IDLE && state_reg != S_OUT))
        else $error("multiplier done outside a step");

    // a finished result never overwrites one that still waits
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !m_axis_tready) |=> state_reg == S_OUT)
        else $error("result dropped while output stalled");

    // once armed, stays armed
    a_armed: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(armed_reg))
        else $error("armed flag cleared");

    // mean divide never sees a zero count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DGO) |-> count_reg != '0)
        else $error("divide by zero count");
`endif

endmodule
